FILE: hw/rtl/rbc_pkg.sv
// shared word types and codes for the block cache slot manager
package rbc_pkg;

    // input word
    typedef struct packed {
        logic [1:0]  mode;
        logic [35:0] block_key;
        logic [5:0]  slot_index;
        logic        fill_ok;
    } t_in_word;

    // result word
    typedef struct packed {
        logic [1:0] status;
        logic [5:0] slot_out;
        logic       was_hit;
        logic       data_ready;
        logic       issue_fetch;
        logic       must_wait;
    } t_out_word;

    // request modes
    localparam logic [1:0] MODE_LOOKUP = 2'd0;
    localparam logic [1:0] MODE_RELEASE = 2'd1;
    localparam logic [1:0] MODE_FILL = 2'd2;
    localparam logic [1:0] MODE_INVAL = 2'd3;

    // status codes
    localparam logic [1:0] STAT_OK = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [1:0] STAT_UNREF = 2'd2;
    localparam logic [1:0] STAT_OVERFLOW = 2'd3;

    // list tags
    localparam logic [1:0] TAG_FREE = 2'd0;
    localparam logic [1:0] TAG_RECLAIM = 2'd1;
    localparam logic [1:0] TAG_BUSY = 2'd2;

    // list selectors
    localparam logic LIST_FREE = 1'b0;
    localparam logic LIST_RECLAIM = 1'b1;

endpackage

FILE: hw/rtl/rbc_mem.sv
// single port pair slot record memory with registered read data
module rbc_mem #(
    parameter int W = 8,
    parameter int D = 2,
    parameter int AW = 1
) (
    input  logic          i_clk,
    input  logic          i_re,
    input  logic [AW-1:0] i_ra,
    output logic [W-1:0]  o_rd,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [W-1:0]  i_wd
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd <= r_mem[i_ra];
        end
    end

    assign o_rd = r_rd;

endmodule

FILE: hw/rtl/refcounted_block_cache_slots.sv
// top level: reference counted block cache slot manager with lru reclaim list
// lookup and invalidate scan the slot memory one entry a cycle
// release and fill done first read the slot record; a slot out of range skips the memory; relinks are rmw steps
// one word is worked on at a time; the result register lets the next word enter while it waits
// after reset a clearing pass over every entry builds the free list; input is stalled meanwhile
module refcounted_block_cache_slots
    import rbc_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int KEY_BITS = 36,
    parameter int REF_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);

    localparam int IW = $clog2(ENTRIES);
    localparam int LW = $clog2(ENTRIES + 1);
    localparam logic [LW-1:0] NONE = LW'(ENTRIES);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    // record layout, low to high
    localparam int OFS_PV = 0;
    localparam int OFS_NX = LW;
    localparam int OFS_TAG = 2 * LW;
    localparam int OFS_FP = 2 * LW + 2;
    localparam int OFS_DV = 2 * LW + 3;
    localparam int OFS_REF = 2 * LW + 4;
    localparam int OFS_IM = OFS_REF + REF_BITS;
    localparam int OFS_HK = OFS_IM + 1;
    localparam int OFS_KEY = OFS_HK + 1;
    localparam int RECW = OFS_KEY + KEY_BITS;

    // sequencer states
    localparam logic [3:0] ST_CLR = 4'd0;
    localparam logic [3:0] ST_IDLE = 4'd1;
    localparam logic [3:0] ST_SCAN = 4'd2;
    localparam logic [3:0] ST_MDEC = 4'd3;
    localparam logic [3:0] ST_DEC = 4'd4;
    localparam logic [3:0] ST_UN1 = 4'd5;
    localparam logic [3:0] ST_UN2 = 4'd6;
    localparam logic [3:0] ST_UN3 = 4'd7;
    localparam logic [3:0] ST_UN4 = 4'd8;
    localparam logic [3:0] ST_AP1 = 4'd9;
    localparam logic [3:0] ST_AP2 = 4'd10;
    localparam logic [3:0] ST_WS = 4'd11;
    localparam logic [3:0] ST_OUT = 4'd12;

    function automatic logic [5:0] f_slot6(input logic [IW-1:0] s);
        logic [12:0] w;
        w = 13'(s);
        return w[5:0];
    endfunction

    logic [3:0]          r_st, n_st;
    logic [IW:0]         r_cnt, n_cnt;
    logic [IW-1:0]       r_cidx, n_cidx;
    logic                r_chk, n_chk;
    logic [1:0]          r_mode, n_mode;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic                r_ok, n_ok;
    logic [IW-1:0]       r_s, n_s;
    logic [KEY_BITS-1:0] r_ekey, n_ekey;
    logic                r_hk, n_hk;
    logic                r_im, n_im;
    logic [REF_BITS-1:0] r_ref, n_ref;
    logic                r_dv, n_dv;
    logic                r_fp, n_fp;
    logic [1:0]          r_tag, n_tag;
    logic [LW-1:0]       r_nx, n_nx;
    logic [LW-1:0]       r_pv, n_pv;
    logic [LW-1:0]       r_up, n_up;
    logic [LW-1:0]       r_un, n_un;
    logic                r_do_un, n_do_un;
    logic                r_unl, n_unl;
    logic                r_do_ap, n_do_ap;
    logic                r_apl, n_apl;
    logic [LW-1:0]       r_head [2];
    logic [LW-1:0]       n_head [2];
    logic [LW-1:0]       r_tail [2];
    logic [LW-1:0]       n_tail [2];
    t_out_word           r_res, n_res;
    t_out_word           r_out, n_out;
    logic                r_ovalid, n_ovalid;

    // memory port controls
    logic          w_re;
    logic [IW-1:0] w_ra;
    logic          w_we;
    logic [IW-1:0] w_wa;
    logic [RECW-1:0] w_wd;
    logic [RECW-1:0] w_rd;

    // record fields of the last read
    logic [LW-1:0]       rd_pv, rd_nx;
    logic [1:0]          rd_tag;
    logic                rd_fp, rd_dv, rd_im, rd_hk;
    logic [REF_BITS-1:0] rd_ref;
    logic [KEY_BITS-1:0] rd_key;

    logic [63:0] w_key64;
    logic [12:0] w_idx13;
    logic [LW-1:0] w_t;

    assign rd_pv = w_rd[OFS_PV +: LW];
    assign rd_nx = w_rd[OFS_NX +: LW];
    assign rd_tag = w_rd[OFS_TAG +: 2];
    assign rd_fp = w_rd[OFS_FP];
    assign rd_dv = w_rd[OFS_DV];
    assign rd_ref = w_rd[OFS_REF +: REF_BITS];
    assign rd_im = w_rd[OFS_IM];
    assign rd_hk = w_rd[OFS_HK];
    assign rd_key = w_rd[OFS_KEY +: KEY_BITS];

    assign w_key64 = 64'(i_in.block_key);
    assign w_idx13 = 13'(i_in.slot_index);
    assign w_t = r_tail[r_apl];

    rbc_mem #(
        .W(RECW),
        .D(ENTRIES),
        .AW(IW)
    ) u_mem (
        .i_clk(i_clk),
        .i_re(w_re),
        .i_ra(w_ra),
        .o_rd(w_rd),
        .i_we(w_we),
        .i_wa(w_wa),
        .i_wd(w_wd)
    );

    // sequencer next state and memory controls
    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        n_cidx = r_cidx;
        n_chk = r_chk;
        n_mode = r_mode;
        n_key = r_key;
        n_ok = r_ok;
        n_s = r_s;
        n_ekey = r_ekey;
        n_hk = r_hk;
        n_im = r_im;
        n_ref = r_ref;
        n_dv = r_dv;
        n_fp = r_fp;
        n_tag = r_tag;
        n_nx = r_nx;
        n_pv = r_pv;
        n_up = r_up;
        n_un = r_un;
        n_do_un = r_do_un;
        n_unl = r_unl;
        n_do_ap = r_do_ap;
        n_apl = r_apl;
        n_head = r_head;
        n_tail = r_tail;
        n_res = r_res;
        n_out = r_out;
        n_ovalid = r_ovalid;
        w_re = 1'b0;
        w_ra = '0;
        w_we = 1'b0;
        w_wa = '0;
        w_wd = w_rd;

        // result register drains
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_st)
            ST_CLR: begin
                // build the initial free list, highest index first
                w_we = 1'b1;
                w_wa = r_cnt[IW-1:0];
                w_wd = '0;
                w_wd[OFS_TAG +: 2] = TAG_FREE;
                w_wd[OFS_NX +: LW] = (r_cnt[IW-1:0] == '0) ? NONE : LW'(r_cnt - 1'b1);
                w_wd[OFS_PV +: LW] = (r_cnt[IW-1:0] == LAST) ? NONE : LW'(r_cnt + 1'b1);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[IW-1:0] == LAST) begin
                    n_st = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_mode = i_in.mode;
                    n_key = w_key64[KEY_BITS-1:0];
                    n_ok = i_in.fill_ok;
                    n_res = '0;
                    if (i_in.mode != MODE_LOOKUP) begin
                        n_res.slot_out = i_in.slot_index;
                    end
                    if (i_in.mode == MODE_LOOKUP || i_in.mode == MODE_INVAL) begin
                        n_cnt = '0;
                        n_chk = 1'b0;
                        n_st = ST_SCAN;
                    end else if (w_idx13 < 13'(ENTRIES)) begin
                        n_s = w_idx13[IW-1:0];
                        w_re = 1'b1;
                        w_ra = w_idx13[IW-1:0];
                        n_st = ST_DEC;
                    end else begin
                        n_st = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_chk && rd_im && rd_key == r_key) begin
                    // mapped key found
                    n_s = r_cidx;
                    if (r_mode == MODE_INVAL) begin
                        w_we = 1'b1;
                        w_wa = r_cidx;
                        w_wd[OFS_IM] = 1'b0;
                        n_st = ST_OUT;
                    end else begin
                        n_res.slot_out = f_slot6(r_cidx);
                        n_res.was_hit = 1'b1;
                        if (&rd_ref) begin
                            n_res.status = STAT_OVERFLOW;
                            n_st = ST_OUT;
                        end else begin
                            n_ekey = rd_key;
                            n_hk = rd_hk;
                            n_im = rd_im;
                            n_ref = rd_ref + 1'b1;
                            n_dv = rd_dv;
                            n_fp = rd_fp;
                            n_tag = TAG_BUSY;
                            if (rd_dv) begin
                                n_res.data_ready = 1'b1;
                            end else if (rd_fp) begin
                                n_res.must_wait = 1'b1;
                            end else begin
                                n_fp = 1'b1;
                                n_res.issue_fetch = 1'b1;
                            end
                            n_do_un = (rd_tag != TAG_BUSY);
                            n_unl = (rd_tag == TAG_RECLAIM);
                            n_up = rd_pv;
                            n_un = rd_nx;
                            n_nx = NONE;
                            n_pv = NONE;
                            n_do_ap = 1'b0;
                            n_st = ST_UN1;
                        end
                    end
                end else if (r_chk && r_cidx == LAST) begin
                    // no mapping: a lookup allocates from free, then reclaim; an invalidate ends here
                    if (r_mode == MODE_INVAL) begin
                        n_st = ST_OUT;
                    end else if (r_head[LIST_FREE] != NONE) begin
                        n_s = r_head[LIST_FREE][IW-1:0];
                        n_unl = LIST_FREE;
                        w_re = 1'b1;
                        w_ra = r_head[LIST_FREE][IW-1:0];
                        n_st = ST_MDEC;
                    end else if (r_head[LIST_RECLAIM] != NONE) begin
                        n_s = r_head[LIST_RECLAIM][IW-1:0];
                        n_unl = LIST_RECLAIM;
                        w_re = 1'b1;
                        w_ra = r_head[LIST_RECLAIM][IW-1:0];
                        n_st = ST_MDEC;
                    end else begin
                        n_res.status = STAT_NO_SLOT;
                        n_st = ST_OUT;
                    end
                end else if (r_cnt < (IW + 1)'(ENTRIES)) begin
                    w_re = 1'b1;
                    w_ra = r_cnt[IW-1:0];
                    n_cidx = r_cnt[IW-1:0];
                    n_chk = 1'b1;
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MDEC: begin
                // new mapping on the taken slot
                n_up = rd_pv;
                n_un = rd_nx;
                n_do_un = 1'b1;
                n_do_ap = 1'b0;
                n_ekey = r_key;
                n_hk = 1'b1;
                n_im = 1'b1;
                n_ref = REF_BITS'(1);
                n_dv = 1'b0;
                n_fp = 1'b1;
                n_tag = TAG_BUSY;
                n_nx = NONE;
                n_pv = NONE;
                n_res.slot_out = f_slot6(r_s);
                n_res.issue_fetch = 1'b1;
                n_st = ST_UN1;
            end
            ST_DEC: begin
                if (r_mode == MODE_FILL) begin
                    w_we = 1'b1;
                    w_wa = r_s;
                    w_wd[OFS_DV] = r_ok;
                    w_wd[OFS_FP] = 1'b0;
                    n_st = ST_OUT;
                end else if (rd_ref == '0) begin
                    n_res.status = STAT_UNREF;
                    n_st = ST_OUT;
                end else begin
                    n_ekey = rd_key;
                    n_hk = rd_hk;
                    n_im = rd_im;
                    n_ref = rd_ref - 1'b1;
                    n_dv = rd_dv;
                    n_fp = rd_fp;
                    n_tag = rd_tag;
                    n_nx = rd_nx;
                    n_pv = rd_pv;
                    n_up = rd_pv;
                    n_un = rd_nx;
                    n_unl = (rd_tag == TAG_RECLAIM);
                    n_apl = rd_hk;
                    if (rd_ref == REF_BITS'(1)) begin
                        n_do_un = (rd_tag != TAG_BUSY);
                        n_do_ap = 1'b1;
                    end else begin
                        n_do_un = 1'b0;
                        n_do_ap = 1'b0;
                    end
                    n_st = ST_UN1;
                end
            end
            ST_UN1: begin
                // unlink: predecessor side
                if (!r_do_un) begin
                    n_st = ST_AP1;
                end else if (r_up == NONE) begin
                    n_head[r_unl] = r_un;
                    n_st = ST_UN3;
                end else begin
                    w_re = 1'b1;
                    w_ra = r_up[IW-1:0];
                    n_st = ST_UN2;
                end
            end
            ST_UN2: begin
                w_we = 1'b1;
                w_wa = r_up[IW-1:0];
                w_wd[OFS_NX +: LW] = r_un;
                n_st = ST_UN3;
            end
            ST_UN3: begin
                // unlink: successor side
                if (r_un == NONE) begin
                    n_tail[r_unl] = r_up;
                    n_st = ST_AP1;
                end else begin
                    w_re = 1'b1;
                    w_ra = r_un[IW-1:0];
                    n_st = ST_UN4;
                end
            end
            ST_UN4: begin
                w_we = 1'b1;
                w_wa = r_un[IW-1:0];
                w_wd[OFS_PV +: LW] = r_up;
                n_st = ST_AP1;
            end
            ST_AP1: begin
                // append at list tail
                if (!r_do_ap) begin
                    n_st = ST_WS;
                end else begin
                    n_pv = w_t;
                    n_nx = NONE;
                    n_tag = r_apl ? TAG_RECLAIM : TAG_FREE;
                    n_tail[r_apl] = LW'(r_s);
                    if (w_t == NONE) begin
                        n_head[r_apl] = LW'(r_s);
                        n_st = ST_WS;
                    end else begin
                        w_re = 1'b1;
                        w_ra = w_t[IW-1:0];
                        n_st = ST_AP2;
                    end
                end
            end
            ST_AP2: begin
                w_we = 1'b1;
                w_wa = r_pv[IW-1:0];
                w_wd[OFS_NX +: LW] = LW'(r_s);
                n_st = ST_WS;
            end
            ST_WS: begin
                // write back the slot record
                w_we = 1'b1;
                w_wa = r_s;
                w_wd = {r_ekey, r_hk, r_im, r_ref, r_dv, r_fp, r_tag, r_nx, r_pv};
                n_st = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || !i_out_stall) begin
                    n_out = r_res;
                    n_ovalid = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: begin
                n_st = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLR;
            r_cnt <= '0;
            r_chk <= 1'b0;
            r_ovalid <= 1'b0;
            r_head[LIST_FREE] <= LW'(ENTRIES - 1);
            r_tail[LIST_FREE] <= '0;
            r_head[LIST_RECLAIM] <= NONE;
            r_tail[LIST_RECLAIM] <= NONE;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_chk <= n_chk;
            r_ovalid <= n_ovalid;
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_cidx <= n_cidx;
        r_mode <= n_mode;
        r_key <= n_key;
        r_ok <= n_ok;
        r_s <= n_s;
        r_ekey <= n_ekey;
        r_hk <= n_hk;
        r_im <= n_im;
        r_ref <= n_ref;
        r_dv <= n_dv;
        r_fp <= n_fp;
        r_tag <= n_tag;
        r_nx <= n_nx;
        r_pv <= n_pv;
        r_up <= n_up;
        r_un <= n_un;
        r_do_un <= n_do_un;
        r_unl <= n_unl;
        r_do_ap <= n_do_ap;
        r_apl <= n_apl;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign o_in_stall = (r_st != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out = r_out;

endmodule
